/* rtl/qxmm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qxmm_pkg
// Shared widths, register indexes and types of the quad X motor mixer.
// ----------------------------------------------------------------------------
package qxmm_pkg;

    // Fixed field widths of the command and duty beats
    localparam int FIELD_W   = 16;
    localparam int MIX_W     = FIELD_W + 2;        // sum of three signed terms
    localparam int SUM_W     = FIELD_W + 1;        // clamped mix plus throttle
    localparam int PROD_W    = SUM_W + FIELD_W;    // sum times gain
    localparam int GAIN_FRAC = 14;                 // Q2.14 gain
    localparam int SCALED_W  = PROD_W - GAIN_FRAC;

    localparam int DUTY_WIDTH_DEF = 16;

    // Configuration register map
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ONE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_TWO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_THREE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_FOUR   = 3'd5;

    localparam logic [FIELD_W-1:0] MIN_DUTY_RST = 16'd0;
    localparam logic [FIELD_W-1:0] MAX_DUTY_RST = 16'd10000;
    localparam logic [FIELD_W-1:0] GAIN_RST     = 16'd16384;

    // Stage advance enables handed to each motor lane
    typedef struct packed {
        logic en_mid;
        logic en_out;
    } t_stage_ctl;

endpackage

/* rtl/qxmm_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qxmm_cmd_if / qxmm_duty_if
// Valid/ready channels for control command beats and motor duty beats.
// ----------------------------------------------------------------------------
interface qxmm_cmd_if;
    import qxmm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] roll_term;
    logic signed [FIELD_W-1:0] pitch_term;
    logic signed [FIELD_W-1:0] yaw_term;
    logic        [FIELD_W-1:0] throttle_level;
    logic                      armed;

    modport source (
        output valid, roll_term, pitch_term, yaw_term, throttle_level, armed,
        input  ready
    );
    modport sink (
        input  valid, roll_term, pitch_term, yaw_term, throttle_level, armed,
        output ready
    );
endinterface

interface qxmm_duty_if;
    import qxmm_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] duty_one;
    logic [FIELD_W-1:0] duty_two;
    logic [FIELD_W-1:0] duty_three;
    logic [FIELD_W-1:0] duty_four;

    modport source (
        output valid, duty_one, duty_two, duty_three, duty_four,
        input  ready
    );
    modport sink (
        input  valid, duty_one, duty_two, duty_three, duty_four,
        output ready
    );
endinterface

/* rtl/qxmm_motor_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qxmm_motor_lane
// One motor: clamp the mix, add throttle, scale by gain, clamp, gate by arm.
// ----------------------------------------------------------------------------
module qxmm_motor_lane #(
    parameter int LIM_W = qxmm_pkg::DUTY_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  qxmm_pkg::t_stage_ctl               i_ctl,
    input  logic signed [qxmm_pkg::MIX_W-1:0]  i_mix,
    input  logic [qxmm_pkg::FIELD_W-1:0]       i_throttle,
    input  logic                               i_armed,
    input  logic [LIM_W-1:0]                   i_min_duty,
    input  logic [LIM_W-1:0]                   i_max_duty,
    input  logic [qxmm_pkg::FIELD_W-1:0]       i_gain,
    output logic [qxmm_pkg::FIELD_W-1:0]       o_duty
);
    import qxmm_pkg::*;

    logic [FIELD_W-1:0]      min16;
    logic [FIELD_W-1:0]      max16;
    logic signed [MIX_W-1:0] lo_s;
    logic signed [MIX_W-1:0] hi_s;
    logic signed [MIX_W-1:0] clamp_lo;
    logic signed [MIX_W-1:0] clamp_hi;
    logic [SUM_W-1:0]        n_sum;
    logic [SUM_W-1:0]        r_sum;
    logic                    r_armed;
    logic [PROD_W-1:0]       prod;
    logic [SCALED_W-1:0]     scaled;
    logic [FIELD_W-1:0]      n_duty;
    logic [FIELD_W-1:0]      r_duty;

    assign min16 = FIELD_W'(i_min_duty);
    assign max16 = FIELD_W'(i_max_duty);
    assign lo_s  = signed'(MIX_W'(min16));
    assign hi_s  = signed'(MIX_W'(max16));

    // lower bound first, then upper: min above max ends at max
    always_comb begin
        clamp_lo = (i_mix < lo_s) ? lo_s : i_mix;
        clamp_hi = (clamp_lo > hi_s) ? hi_s : clamp_lo;
        n_sum    = SUM_W'(clamp_hi[FIELD_W-1:0]) + SUM_W'(i_throttle);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_mid) begin
            r_sum   <= n_sum;
            r_armed <= i_armed;
        end
    end

    // upper bound tested first, lower only if the upper did not fire
    always_comb begin
        prod   = PROD_W'(r_sum) * PROD_W'(i_gain);
        scaled = prod[PROD_W-1:GAIN_FRAC];
        if (scaled > SCALED_W'(max16)) begin
            n_duty = max16;
        end else if (scaled < SCALED_W'(min16)) begin
            n_duty = min16;
        end else begin
            n_duty = scaled[FIELD_W-1:0];
        end
        if (!r_armed) begin
            n_duty = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_out) begin
            r_duty <= n_duty;
        end
    end

    assign o_duty = r_duty;

endmodule

/* rtl/quad_x_motor_mixer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_x_motor_mixer_unit
// X-frame quadcopter mixer: roll, pitch, yaw and throttle to four PWM duties.
// ----------------------------------------------------------------------------
// Each command beat (roll, pitch, yaw, throttle, armed) yields one duty beat
// for four motors: m1=+r-p-y, m2=-r-p+y, m3=+r+p+y, m4=-r+p-y. Each mix is
// clamped to [min_duty, max_duty], throttle is added, the sum is scaled by
// the motor's unsigned Q2.14 gain (truncated), clamped again and driven out;
// a disarmed beat gives all zeros. The datapath is a three-register pipeline
// (command register, throttle-sum register, duty register), so a beat is
// accepted every clock while the sink keeps up; its duties pass through the
// three registers in that order and are presented from the duty register.
// The one 17x16 gain multiply per motor sits alone
// between the sum and duty registers. Back-pressure stalls the pipeline
// stage by stage, and bubbles are squeezed out. Configuration writes
// (index 0 min_duty, 1 max_duty, 2..5 gains) take effect at once and are
// meant to happen while no beat is in flight. DUTY_WIDTH masks the duty
// limits to that many bits (above 16 it has no further effect).
// ----------------------------------------------------------------------------
module quad_x_motor_mixer_unit #(
    parameter int DUTY_WIDTH = qxmm_pkg::DUTY_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [qxmm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [qxmm_pkg::FIELD_W-1:0]     i_cfg_data,
    qxmm_cmd_if.sink                         i_cmd,
    qxmm_duty_if.source                      o_duty
);
    import qxmm_pkg::*;

    // Limit registers never hold more than the 16-bit field
    localparam int LIM_W = (DUTY_WIDTH < FIELD_W) ? DUTY_WIDTH : FIELD_W;

    // ---------------- configuration registers ----------------
    logic [LIM_W-1:0]   r_min_duty;
    logic [LIM_W-1:0]   r_max_duty;
    logic [FIELD_W-1:0] r_gain [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_duty <= MIN_DUTY_RST[LIM_W-1:0];
            r_max_duty <= MAX_DUTY_RST[LIM_W-1:0];
            for (int k = 0; k < 4; k++) begin
                r_gain[k] <= GAIN_RST;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MIN_DUTY:   r_min_duty <= i_cfg_data[LIM_W-1:0];
                REG_MAX_DUTY:   r_max_duty <= i_cfg_data[LIM_W-1:0];
                REG_GAIN_ONE:   r_gain[0]  <= i_cfg_data;
                REG_GAIN_TWO:   r_gain[1]  <= i_cfg_data;
                REG_GAIN_THREE: r_gain[2]  <= i_cfg_data;
                REG_GAIN_FOUR:  r_gain[3]  <= i_cfg_data;
                default: ;      // unmapped index: write dropped
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // A stage loads when it is empty or its content moves on this cycle.
    logic       r_in_vld;
    logic       r_mid_vld;
    logic       r_out_vld;
    logic       en_in;
    t_stage_ctl ctl;

    assign ctl.en_out = !r_out_vld || o_duty.ready;
    assign ctl.en_mid = !r_mid_vld || ctl.en_out;
    assign en_in      = !r_in_vld  || ctl.en_mid;

    assign i_cmd.ready  = en_in;
    assign o_duty.valid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_mid_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (en_in)      r_in_vld  <= i_cmd.valid;
            if (ctl.en_mid) r_mid_vld <= r_in_vld;
            if (ctl.en_out) r_out_vld <= r_mid_vld;
        end
    end

    // ---------------- command register ----------------
    logic signed [FIELD_W-1:0] r_roll;
    logic signed [FIELD_W-1:0] r_pitch;
    logic signed [FIELD_W-1:0] r_yaw;
    logic        [FIELD_W-1:0] r_throttle;
    logic                      r_armed;

    always_ff @(posedge i_clk) begin
        if (en_in && i_cmd.valid) begin
            r_roll     <= i_cmd.roll_term;
            r_pitch    <= i_cmd.pitch_term;
            r_yaw      <= i_cmd.yaw_term;
            r_throttle <= i_cmd.throttle_level;
            r_armed    <= i_cmd.armed;
        end
    end

    // ---------------- X-frame mix ----------------
    logic signed [MIX_W-1:0] roll_x;
    logic signed [MIX_W-1:0] pitch_x;
    logic signed [MIX_W-1:0] yaw_x;
    logic signed [MIX_W-1:0] mix [4];

    assign roll_x  = MIX_W'(r_roll);
    assign pitch_x = MIX_W'(r_pitch);
    assign yaw_x   = MIX_W'(r_yaw);

    always_comb begin
        mix[0] =  roll_x - pitch_x - yaw_x;   // front right, CCW
        mix[1] = -roll_x - pitch_x + yaw_x;
        mix[2] =  roll_x + pitch_x + yaw_x;
        mix[3] = -roll_x + pitch_x - yaw_x;
    end

    logic [FIELD_W-1:0] duty [4];

    for (genvar g = 0; g < 4; g++) begin : g_lane
        qxmm_motor_lane #(
            .LIM_W (LIM_W)
        ) u_lane (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_mix      (mix[g]),
            .i_throttle (r_throttle),
            .i_armed    (r_armed),
            .i_min_duty (r_min_duty),
            .i_max_duty (r_max_duty),
            .i_gain     (r_gain[g]),
            .o_duty     (duty[g])
        );
    end

    assign o_duty.duty_one   = duty[0];
    assign o_duty.duty_two   = duty[1];
    assign o_duty.duty_three = duty[2];
    assign o_duty.duty_four  = duty[3];

    // ---------------- checks ----------------
    // An empty duty register never back-pressures the command side.
    a_ready_when_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> i_cmd.ready)
        else $error("command stalled with free duty register");

    // A beat held in the sum stage is not dropped while stalled.
    a_mid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mid_vld && !ctl.en_mid) |=> r_mid_vld)
        else $error("stalled sum-stage beat lost");

    // An accepted command lands in the command register.
    a_cmd_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> r_in_vld)
        else $error("accepted command not captured");

endmodule
